// ===== hw/rtl/tlpqs_pkg.sv =====
package tlpqs_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int BURST_BITS_DEF  = 16;

    localparam int ID_W       = 8;
    localparam int IN_BURST_W = 16;
    localparam int TIME_W     = 32;
    localparam int STATUS_W   = 3;

    // s_tdata: job_id, burst, is_system, zero fill
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 1;
    // m_tdata: served_id, now
    localparam int M_TDATA_W = 40;

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPT = 3'd0,
        ST_REJECT = 3'd1,
        ST_IDLE   = 3'd2,
        ST_RAN    = 3'd3,
        ST_DONE   = 3'd4
    } status_t;

    typedef enum logic {
        CS_IDLE,
        CS_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } dp_cmd_t;

endpackage

// ===== hw/rtl/tlpqs_ctrl.sv =====
module tlpqs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output tlpqs_pkg::dp_cmd_t cmd
);
    import tlpqs_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CS_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        out_free     = !m_valid_reg || m_tready;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        s_tready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            CS_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = CS_EXEC;
                end
            end
            CS_EXEC: begin
                // result register must be free before state is touched
                if (out_free) begin
                    cmd.execute  = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = CS_IDLE;
                end
            end
            default: state_next = CS_IDLE;
        endcase
    end

    assign m_tvalid = m_valid_reg;

endmodule

// ===== hw/rtl/tlpqs_dp.sv =====
module tlpqs_dp #(
    parameter int QUEUE_DEPTH = tlpqs_pkg::QUEUE_DEPTH_DEF,
    parameter int BURST_BITS  = tlpqs_pkg::BURST_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  tlpqs_pkg::dp_cmd_t             cmd,
    input  logic [tlpqs_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [tlpqs_pkg::S_TUSER_W-1:0] s_tuser,
    output logic [tlpqs_pkg::STATUS_W-1:0]  out_status,
    output logic [tlpqs_pkg::ID_W-1:0]      out_id,
    output logic [tlpqs_pkg::TIME_W-1:0]    out_now
);
    import tlpqs_pkg::*;

    localparam int ADDR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = ID_W + BURST_BITS;
    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [ADDR_W-1:0] PTR_LAST = ADDR_W'(QUEUE_DEPTH - 1);

    function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    // captured item
    logic                  in_op_reg;
    logic [ID_W-1:0]       in_id_reg;
    logic [BURST_BITS-1:0] in_burst_reg;
    logic                  in_sys_reg;
    logic [BURST_BITS+IN_BURST_W-1:0] burst_ext;

    // queue memories and pointers
    logic [ENTRY_W-1:0] sys_mem  [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] user_mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] sys_rd_reg, user_rd_reg;
    logic [ADDR_W-1:0]  sys_head_reg, sys_tail_reg, user_head_reg, user_tail_reg;
    logic [CNT_W-1:0]   sys_cnt_reg, user_cnt_reg;

    // running job and time
    logic                  run_valid_reg, run_user_reg;
    logic [ID_W-1:0]       run_id_reg;
    logic [BURST_BITS-1:0] run_rem_reg;
    logic [TIME_W-1:0]     time_reg;

    logic [STATUS_W-1:0] status_reg;
    logic [ID_W-1:0]     served_reg;

    // execute decisions
    logic sys_empty, sys_full, user_empty, user_full;
    logic preempt, keep_run, pop_sys, pop_user, have_job, done;
    logic arr_ok, sys_push, user_push;
    logic [ID_W-1:0]       job_id;
    logic [BURST_BITS-1:0] job_rem, rem_dec;
    logic [ENTRY_W-1:0]    user_wdata;
    status_t               status_c;
    logic [ID_W-1:0]       served_c;

    assign burst_ext = {{BURST_BITS{1'b0}}, s_tdata[ID_W +: IN_BURST_W]};

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_op_reg    <= s_tuser[0];
            in_id_reg    <= s_tdata[ID_W-1:0];
            in_burst_reg <= burst_ext[BURST_BITS-1:0];
            in_sys_reg   <= s_tdata[ID_W+IN_BURST_W];
        end
    end

    always_comb begin
        sys_empty  = (sys_cnt_reg == '0);
        sys_full   = (sys_cnt_reg == CNT_FULL);
        user_empty = (user_cnt_reg == '0);
        user_full  = (user_cnt_reg == CNT_FULL);

        // a user job yields to system work only if it fits back in its queue
        preempt  = run_valid_reg && run_user_reg && !sys_empty && !user_full;
        keep_run = run_valid_reg && !preempt;
        pop_sys  = !keep_run && !sys_empty;
        pop_user = !keep_run && sys_empty && !user_empty;
        have_job = keep_run || pop_sys || pop_user;

        if (pop_sys) begin
            job_id  = sys_rd_reg[ID_W-1:0];
            job_rem = sys_rd_reg[ENTRY_W-1:ID_W];
        end else if (pop_user) begin
            job_id  = user_rd_reg[ID_W-1:0];
            job_rem = user_rd_reg[ENTRY_W-1:ID_W];
        end else begin
            job_id  = run_id_reg;
            job_rem = run_rem_reg;
        end
        rem_dec = (job_rem != '0) ? job_rem - 1'b1 : job_rem;
        done    = (rem_dec == '0);

        arr_ok = (in_burst_reg != '0) && (in_sys_reg ? !sys_full : !user_full);

        if (in_op_reg == OP_ARRIVE) begin
            sys_push   = arr_ok && in_sys_reg;
            user_push  = arr_ok && !in_sys_reg;
            user_wdata = {in_burst_reg, in_id_reg};
            status_c   = arr_ok ? ST_ACCEPT : ST_REJECT;
            served_c   = in_id_reg;
        end else begin
            sys_push   = 1'b0;
            user_push  = preempt;
            user_wdata = {run_rem_reg, run_id_reg};
            if (!have_job) begin
                status_c = ST_IDLE;
            end else if (done) begin
                status_c = ST_DONE;
            end else begin
                status_c = ST_RAN;
            end
            served_c = have_job ? job_id : '0;
        end
    end

    // queue memories: registered read at the head, write at the tail
    always_ff @(posedge aclk) begin
        sys_rd_reg  <= sys_mem[sys_head_reg];
        user_rd_reg <= user_mem[user_head_reg];
        if (cmd.execute && sys_push) begin
            sys_mem[sys_tail_reg] <= {in_burst_reg, in_id_reg};
        end
        if (cmd.execute && user_push) begin
            user_mem[user_tail_reg] <= user_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sys_head_reg  <= '0;
            sys_tail_reg  <= '0;
            sys_cnt_reg   <= '0;
            user_head_reg <= '0;
            user_tail_reg <= '0;
            user_cnt_reg  <= '0;
            run_valid_reg <= 1'b0;
            run_user_reg  <= 1'b0;
            run_id_reg    <= '0;
            run_rem_reg   <= '0;
            time_reg      <= '0;
        end else if (cmd.execute) begin
            if (in_op_reg == OP_ARRIVE) begin
                if (sys_push) begin
                    sys_tail_reg <= ptr_inc(sys_tail_reg);
                    sys_cnt_reg  <= sys_cnt_reg + 1'b1;
                end
                if (user_push) begin
                    user_tail_reg <= ptr_inc(user_tail_reg);
                    user_cnt_reg  <= user_cnt_reg + 1'b1;
                end
            end else begin
                time_reg <= time_reg + 1'b1;
                if (pop_sys) begin
                    sys_head_reg <= ptr_inc(sys_head_reg);
                    sys_cnt_reg  <= sys_cnt_reg - 1'b1;
                end
                if (preempt) begin
                    user_tail_reg <= ptr_inc(user_tail_reg);
                    user_cnt_reg  <= user_cnt_reg + 1'b1;
                end
                if (pop_user) begin
                    user_head_reg <= ptr_inc(user_head_reg);
                    user_cnt_reg  <= user_cnt_reg - 1'b1;
                end
                if (have_job) begin
                    run_id_reg    <= job_id;
                    run_rem_reg   <= rem_dec;
                    run_valid_reg <= !done;
                    if (done) begin
                        run_user_reg <= 1'b0;
                    end else if (pop_sys) begin
                        run_user_reg <= 1'b0;
                    end else if (pop_user) begin
                        run_user_reg <= 1'b1;
                    end
                end else begin
                    run_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            status_reg <= status_c;
            served_reg <= served_c;
        end
    end

    assign out_status = status_reg;
    assign out_id     = served_reg;
    assign out_now    = time_reg;

endmodule

// ===== hw/rtl/two_level_preemptive_queue_scheduler.sv =====
// Two-level preemptive scheduler with a system and a user job queue. Each input
// transaction is an arrival (tuser 0) or a time tick (tuser 1) and yields exactly
// one result transaction. Each item is first captured, then executed against the
// head entries that the queue memories present on their registered read ports.
// The next item is taken as soon as the result is loaded into the output register;
// execution waits only while that register still holds an untaken result. Queue
// memories have no reset and need no clearing pass.
module two_level_preemptive_queue_scheduler #(
    parameter int QUEUE_DEPTH = tlpqs_pkg::QUEUE_DEPTH_DEF,
    parameter int BURST_BITS  = tlpqs_pkg::BURST_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tlpqs_pkg::S_TDATA_W-1:0] s_tdata,  // job_id, burst, is_system
    input  logic [tlpqs_pkg::S_TUSER_W-1:0] s_tuser,  // opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tlpqs_pkg::M_TDATA_W-1:0] m_tdata,  // served_id, now
    output logic [tlpqs_pkg::STATUS_W-1:0]  m_tuser   // status
);
    import tlpqs_pkg::*;

    dp_cmd_t           cmd;
    logic [ID_W-1:0]   out_id;
    logic [TIME_W-1:0] out_now;

    tlpqs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    tlpqs_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .BURST_BITS  (BURST_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .out_status (m_tuser),
        .out_id     (out_id),
        .out_now    (out_now)
    );

    assign m_tdata = {out_now, out_id};

endmodule

// ===== hw/rtl/tlpqs_checker.sv =====
module tlpqs_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [tlpqs_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [tlpqs_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [tlpqs_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [tlpqs_pkg::STATUS_W-1:0]  m_tuser
);
    import tlpqs_pkg::*;

    logic s_xact;
    logic s_tick_xact;
    assign s_xact      = s_tvalid && s_tready;
    assign s_tick_xact = s_xact && (s_tuser[0] == OP_TICK) && (s_tdata != '0);

    // one item in flight: no new transaction right after one is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xact |=> !s_tready)
        else $error("input taken while an item is still executing");

    // a fresh result always traces back to a taken transaction, through capture and execute
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_xact, 2))
        else $error("result appeared without a matching input");

    // an idle tick never names a job
    a_idle_no_job: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == ST_IDLE)) |-> (m_tdata[ID_W-1:0] == '0))
        else $error("idle tick reports a served job");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // a tick never answers as an arrival
    a_tick_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tick_xact && !m_tvalid) |=> ##1
            (m_tuser != ST_ACCEPT && m_tuser != ST_REJECT))
        else $error("tick answered with an arrival status");

endmodule

bind two_level_preemptive_queue_scheduler tlpqs_checker u_tlpqs_checker (.*);
